// ----- rtl/core/qnorm_pkg.sv -----
// ============================================================================
// qnorm_pkg
// Shared constants, widths and types for the quaternion normalizer.
// ============================================================================
package qnorm_pkg;

    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_LANES      = 4;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_lane_ctl;

endpackage

// ----- rtl/core/qnorm_sq_tree.sv -----
// ============================================================================
// qnorm_sq_tree
// Per-lane absolute value and square, registered adder tree to the sum.
// ============================================================================
module qnorm_sq_tree #(
    parameter int COMP_WIDTH = qnorm_pkg::COMP_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic [COMP_WIDTH-1:0]         i_comp [qnorm_pkg::NUM_LANES],
    output logic [COMP_WIDTH-1:0]         o_abs  [qnorm_pkg::NUM_LANES],
    output logic                          o_neg  [qnorm_pkg::NUM_LANES],
    output logic [2*COMP_WIDTH+1:0]       o_sum
);
    import qnorm_pkg::*;

    localparam int SQW = 2 * COMP_WIDTH;

    logic [COMP_WIDTH-1:0] r_abs [NUM_LANES];
    logic                  r_neg [NUM_LANES];
    logic [SQW-1:0]        r_sq  [NUM_LANES];
    logic [COMP_WIDTH-1:0] r_abs2 [NUM_LANES];
    logic                  r_neg2 [NUM_LANES];
    logic [SQW:0]          r_pair [2];
    logic [COMP_WIDTH-1:0] r_abs3 [NUM_LANES];
    logic                  r_neg3 [NUM_LANES];
    logic [SQW+1:0]        r_sum;
    logic [COMP_WIDTH-1:0] r_abs4 [NUM_LANES];
    logic                  r_neg4 [NUM_LANES];

    always_ff @(posedge i_clk) begin
        for (int n = 0; n < NUM_LANES; n++) begin
            r_neg[n]  <= i_comp[n][COMP_WIDTH-1];
            r_abs[n]  <= i_comp[n][COMP_WIDTH-1] ? (~i_comp[n] + 1'b1) : i_comp[n];
            r_sq[n]   <= SQW'(r_abs[n]) * SQW'(r_abs[n]);
            r_abs2[n] <= r_abs[n];
            r_neg2[n] <= r_neg[n];
            r_abs3[n] <= r_abs2[n];
            r_neg3[n] <= r_neg2[n];
            r_abs4[n] <= r_abs3[n];
            r_neg4[n] <= r_neg3[n];
        end
        r_pair[0] <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
        r_pair[1] <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
        r_sum     <= {1'b0, r_pair[0]} + {1'b0, r_pair[1]};
    end

    always_comb begin
        for (int n = 0; n < NUM_LANES; n++) begin
            o_abs[n] = r_abs4[n];
            o_neg[n] = r_neg4[n];
        end
    end
    assign o_sum = r_sum;

endmodule

// ----- rtl/core/qnorm_sqrt.sv -----
// ============================================================================
// qnorm_sqrt
// Pipelined restoring square root, one result bit per stage.
// ============================================================================
module qnorm_sqrt #(
    parameter int IN_W  = 2 * qnorm_pkg::COMP_WIDTH_DEF + 2,
    parameter int OUT_W = qnorm_pkg::COMP_WIDTH_DEF + 1
) (
    input  logic               i_clk,
    input  logic [IN_W-1:0]    i_rad,
    output logic [OUT_W-1:0]   o_root
);
    localparam int RW = 2 * OUT_W;

    logic [RW-1:0]    r_rad  [OUT_W+1];
    logic [OUT_W-1:0] r_root [OUT_W+1];

    always_comb begin
        r_rad[0]  = RW'(i_rad);
        r_root[0] = '0;
    end

    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        localparam int B = OUT_W - 1 - s;
        logic [OUT_W-1:0] c;
        logic [RW-1:0]    csq;
        // c*c = root^2 + root*2^(B+1) + 2^(2B); root^2 tracked via remainder
        assign c   = r_root[s] | (OUT_W'(1) << B);
        assign csq = (RW'(r_root[s]) << (B + 1)) | (RW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (csq <= r_rad[s]) begin
                r_rad[s+1]  <= r_rad[s] - csq;
                r_root[s+1] <= c;
            end else begin
                r_rad[s+1]  <= r_rad[s];
                r_root[s+1] <= r_root[s];
            end
        end
    end

    assign o_root = r_root[OUT_W];

endmodule

// ----- rtl/core/qnorm_div.sv -----
// ============================================================================
// qnorm_div
// Pipelined restoring divider: floor(a * 2^FRAC_BITS / d), a <= d, d > 0.
// ============================================================================
module qnorm_div #(
    parameter int COMP_WIDTH = qnorm_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qnorm_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [COMP_WIDTH-1:0] i_num,
    input  logic [COMP_WIDTH:0]   i_den,
    output logic [FRAC_BITS:0]    o_quo
);
    localparam int QW = FRAC_BITS + 1;
    localparam int DW = COMP_WIDTH + 1;

    logic [DW:0]   r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_quo [QW+1];

    always_comb begin
        r_rem[0] = (DW+1)'(i_num);
        r_den[0] = i_den;
        r_quo[0] = '0;
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW:0] t;
        assign t = (s == 0) ? r_rem[s] : {r_rem[s][DW-1:0], 1'b0};
        always_ff @(posedge i_clk) begin
            r_den[s+1] <= r_den[s];
            if (t >= {1'b0, r_den[s]}) begin
                r_rem[s+1] <= t - {1'b0, r_den[s]};
                r_quo[s+1] <= {r_quo[s][QW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= t;
                r_quo[s+1] <= {r_quo[s][QW-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo[QW];

endmodule

// ----- rtl/core/quaternion_normalizer.sv -----
// ============================================================================
// quaternion_normalizer
// Scales one quaternion to unit length; reports the magnitude and zero flag.
// ============================================================================
// One item per cycle; busy stays low. The path runs through the square
// tree, one square-root stage per magnitude bit, then four divider lanes
// with one stage per quotient bit, then the merging output register. Each
// result shows for one cycle on o_valid and cannot be held off.
module quaternion_normalizer #(
    parameter int COMP_WIDTH = qnorm_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qnorm_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [COMP_WIDTH-1:0]   i_comp_real,
    input  logic [COMP_WIDTH-1:0]   i_comp_i,
    input  logic [COMP_WIDTH-1:0]   i_comp_j,
    input  logic [COMP_WIDTH-1:0]   i_comp_k,
    output logic                    o_valid,
    output logic [FRAC_BITS+1:0]    o_unit_real,
    output logic [FRAC_BITS+1:0]    o_unit_i,
    output logic [FRAC_BITS+1:0]    o_unit_j,
    output logic [FRAC_BITS+1:0]    o_unit_k,
    output logic [COMP_WIDTH:0]     o_magnitude,
    output logic                    o_zero_norm
);
    import qnorm_pkg::*;

    localparam int MW   = COMP_WIDTH + 1;
    localparam int SQL  = 4;
    localparam int QL   = FRAC_BITS + 1;
    localparam int LAT  = SQL + MW + QL;
    localparam int UW   = FRAC_BITS + 2;

    logic [COMP_WIDTH-1:0] comp [NUM_LANES];
    logic [COMP_WIDTH-1:0] abs_v [NUM_LANES];
    logic                  neg_v [NUM_LANES];
    logic [2*COMP_WIDTH+1:0] sum;
    logic [MW-1:0]         root;
    logic [QL-1:0]         quo [NUM_LANES];

    logic [COMP_WIDTH-1:0] r_abs_d [MW][NUM_LANES];
    logic                  r_neg_d [MW+QL][NUM_LANES];
    logic [MW-1:0]         r_mag_d [QL];
    logic [LAT-1:0]        r_vld;
    t_lane_ctl             r_ctl;
    logic [UW-1:0]         r_unit [NUM_LANES];
    logic [MW-1:0]         r_mag;

    assign comp[0] = i_comp_real;
    assign comp[1] = i_comp_i;
    assign comp[2] = i_comp_j;
    assign comp[3] = i_comp_k;
    assign busy    = 1'b0;

    qnorm_sq_tree #(.COMP_WIDTH(COMP_WIDTH)) u_sq (
        .i_clk(i_clk), .i_comp(comp), .o_abs(abs_v), .o_neg(neg_v), .o_sum(sum)
    );

    qnorm_sqrt #(.IN_W(2*COMP_WIDTH+2), .OUT_W(MW)) u_sqrt (
        .i_clk(i_clk), .i_rad(sum), .o_root(root)
    );

    always_ff @(posedge i_clk) begin
        r_abs_d[0] <= abs_v;
        for (int s = 1; s < MW; s++) r_abs_d[s] <= r_abs_d[s-1];
        r_neg_d[0] <= neg_v;
        for (int s = 1; s < MW + QL; s++) r_neg_d[s] <= r_neg_d[s-1];
        r_mag_d[0] <= root;
        for (int s = 1; s < QL; s++) r_mag_d[s] <= r_mag_d[s-1];
    end

    for (genvar n = 0; n < NUM_LANES; n++) begin : g_lane
        qnorm_div #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk(i_clk),
            .i_num(r_abs_d[MW-1][n]),
            .i_den((root == '0) ? MW'(1) : root),
            .o_quo(quo[n])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ctl <= '0;
        end else begin
            r_vld       <= {r_vld[LAT-2:0], start};
            r_ctl.valid <= r_vld[LAT-1];
            r_ctl.zero  <= (r_mag_d[QL-1] == '0);
        end
        r_mag <= r_mag_d[QL-1];
        for (int n = 0; n < NUM_LANES; n++) begin
            if (r_mag_d[QL-1] == '0)
                r_unit[n] <= '0;
            else if (r_neg_d[MW+QL-1][n])
                r_unit[n] <= UW'(0) - UW'(quo[n]);
            else
                r_unit[n] <= UW'(quo[n]);
        end
    end

    assign o_valid     = r_ctl.valid;
    assign o_zero_norm = r_ctl.zero;
    assign o_magnitude = r_mag;
    assign o_unit_real = r_unit[0];
    assign o_unit_i    = r_unit[1];
    assign o_unit_j    = r_unit[2];
    assign o_unit_k    = r_unit[3];

endmodule

// ----- rtl/core/qnorm_checker.sv -----
// ============================================================================
// qnorm_checker
// Port-level checks for the quaternion normalizer, bound to the top level.
// ============================================================================
module qnorm_checker #(
    parameter int COMP_WIDTH = qnorm_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qnorm_pkg::FRAC_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  busy,
    input logic                  o_valid,
    input logic [FRAC_BITS+1:0]  o_unit_real,
    input logic [FRAC_BITS+1:0]  o_unit_i,
    input logic [COMP_WIDTH:0]   o_magnitude,
    input logic                  o_zero_norm
);
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_norm |-> o_unit_real == '0 && o_unit_i == '0)
        else $error("zero norm with nonzero unit");
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_zero_norm == (o_magnitude == '0))
        else $error("flag and magnitude disagree");
endmodule

bind quaternion_normalizer qnorm_checker #(
    .COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_qnorm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy), .o_valid(o_valid),
    .o_unit_real(o_unit_real), .o_unit_i(o_unit_i),
    .o_magnitude(o_magnitude), .o_zero_norm(o_zero_norm)
);
